// ===== design/sorted_table_heap_allocator_defines.svh =====
// ----------------------------------------------------------------------------
// Sorted table heap allocator: assertion macros
// Clocked checks on clk, switched off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_HEAP_ALLOCATOR_DEFINES_SVH
`define SORTED_TABLE_HEAP_ALLOCATOR_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define SHTA_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("shta: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define SHTA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("shta: next-cycle check failed");

`endif

// ===== design/shta_pkg.sv =====
// ----------------------------------------------------------------------------
// shta_pkg
// Shared types and constants of the sorted table heap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package shta_pkg;

	localparam int HEAP_BYTES_DEF  = 128;
	localparam int TABLE_SLOTS_DEF = 8;

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_COMMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic commit;
	} dp_cmd_t;

endpackage

`default_nettype wire

// ===== design/shta_ctrl.sv =====
// ----------------------------------------------------------------------------
// shta_ctrl
// Request sequencer: accept, scan the table, commit and hand over the result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_table_heap_allocator_defines.svh"

module shta_ctrl import shta_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_stall,
	output logic         out_valid,
	input  wire logic    out_stall,
	output dp_cmd_t      cmd
);

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   out_free;
	logic   take;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_nxt = S_SCAN;
			end
			S_SCAN: begin
				state_nxt = S_COMMIT;
			end
			S_COMMIT: begin
				if (out_free) state_nxt = in_valid ? S_SCAN : S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_comb begin
		take       = 1'b0;
		cmd.scan   = 1'b0;
		cmd.commit = 1'b0;
		case (state_q)
			S_IDLE: begin
				take = 1'b1;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
			end
			S_COMMIT: begin
				take       = out_free;
				cmd.commit = out_free;
			end
			default: begin
				take = 1'b0;
			end
		endcase
		in_stall = !take;
		cmd.load = take && in_valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.commit) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	`SHTA_ASSERT_SAME(a_commit_room, cmd.commit, !out_valid_q || !out_stall)
	`SHTA_ASSERT_NEXT(a_commit_shows, cmd.commit, out_valid_q)
	`SHTA_ASSERT_SAME(a_take_point, !in_stall, state_q == S_IDLE || cmd.commit)
	`SHTA_ASSERT_NEXT(a_accept_scans, in_valid && !in_stall, state_q == S_SCAN)

endmodule

`default_nettype wire

// ===== design/shta_dp.sv =====
// ----------------------------------------------------------------------------
// shta_dp
// Entry table, per-slot fit and match flags, insert and remove shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module shta_dp import shta_pkg::*; #(
	parameter int HEAP_BYTES  = HEAP_BYTES_DEF,
	parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire dp_cmd_t    cmd,
	input  wire logic       action,
	input  wire logic [7:0] req_size,
	input  wire logic [7:0] free_offset,
	output logic            ok,
	output logic [7:0]      block_offset
);

	localparam logic [9:0] HEAP_LIM = 10'(HEAP_BYTES);
	localparam logic [TABLE_SLOTS-1:0] ONES = '1;

	logic       act_q;
	logic [7:0] size_q;
	logic [7:0] foff_q;

	logic [7:0] off_q [TABLE_SLOTS];
	logic [7:0] len_q [TABLE_SLOTS];

	logic [TABLE_SLOTS-1:0] tail_s1;
	logic [TABLE_SLOTS-1:0] gap_s1;
	logic [TABLE_SLOTS-1:0] match_s1;
	logic                   reject_s1;

	logic [TABLE_SLOTS-1:0] used;
	logic [8:0]             prev_end [TABLE_SLOTS];
	logic [9:0]             need     [TABLE_SLOTS];
	logic [TABLE_SLOTS-1:0] tail_c;
	logic [TABLE_SLOTS-1:0] gap_c;
	logic [TABLE_SLOTS-1:0] match_c;

	logic [TABLE_SLOTS-1:0] gap_first;
	logic [TABLE_SLOTS-1:0] pick;
	logic [TABLE_SLOTS-1:0] ins_ge;
	logic [TABLE_SLOTS-1:0] rem_ge;
	logic                   alloc_hit;
	logic                   free_hit;
	logic [7:0]             new_off;
	logic [7:0]             nxt_off [TABLE_SLOTS];
	logic [7:0]             nxt_len [TABLE_SLOTS];

	always_comb begin
		prev_end[0] = '0;
		for (int k = 1; k < TABLE_SLOTS; k++) begin
			prev_end[k] = {1'b0, off_q[k-1]} + {1'b0, len_q[k-1]};
		end
		for (int k = 0; k < TABLE_SLOTS; k++) begin
			used[k]    = len_q[k] != 8'd0;
			need[k]    = {1'b0, prev_end[k]} + {2'b00, size_q};
			gap_c[k]   = used[k] && (need[k] <= {2'b00, off_q[k]});
			match_c[k] = used[k] && (off_q[k] == foff_q);
		end
		tail_c[0] = !used[0] && (need[0] <= HEAP_LIM);
		for (int k = 1; k < TABLE_SLOTS; k++) begin
			tail_c[k] = used[k-1] && !used[k] && (need[k] <= HEAP_LIM);
		end
	end

	always_comb begin
		for (int k = 0; k < TABLE_SLOTS; k++) begin
			gap_first[k] = gap_s1[k] && !(|(gap_s1 & (ONES >> (TABLE_SLOTS - k))));
		end
		pick      = (|tail_s1) ? tail_s1 : gap_first;
		alloc_hit = !reject_s1 && (|pick);
		free_hit  = |match_s1;
		new_off   = '0;
		for (int k = 0; k < TABLE_SLOTS; k++) begin
			ins_ge[k] = |(pick & (ONES >> (TABLE_SLOTS - 1 - k)));
			rem_ge[k] = |(match_s1 & (ONES >> (TABLE_SLOTS - 1 - k)));
			new_off   = new_off | (pick[k] ? prev_end[k][7:0] : 8'd0);
		end
		for (int k = 0; k < TABLE_SLOTS; k++) begin
			nxt_off[k] = off_q[k];
			nxt_len[k] = len_q[k];
		end
		if (act_q == ACT_ALLOC) begin
			if (alloc_hit) begin
				if (pick[0]) begin
					nxt_off[0] = new_off;
					nxt_len[0] = size_q;
				end
				for (int k = 1; k < TABLE_SLOTS; k++) begin
					if (pick[k]) begin
						nxt_off[k] = new_off;
						nxt_len[k] = size_q;
					end else if (ins_ge[k]) begin
						nxt_off[k] = off_q[k-1];
						nxt_len[k] = len_q[k-1];
					end
				end
			end
		end else if (free_hit) begin
			for (int k = 0; k < TABLE_SLOTS - 1; k++) begin
				if (rem_ge[k]) begin
					nxt_off[k] = off_q[k+1];
					nxt_len[k] = len_q[k+1];
				end
			end
			nxt_off[TABLE_SLOTS-1] = '0;
			nxt_len[TABLE_SLOTS-1] = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q  <= action;
			size_q <= req_size;
			foff_q <= free_offset;
		end
		if (cmd.scan) begin
			tail_s1   <= tail_c;
			gap_s1    <= gap_c;
			match_s1  <= match_c;
			reject_s1 <= (size_q == 8'd0) || ({2'b00, size_q} > HEAP_LIM)
				|| used[TABLE_SLOTS-1];
		end
		if (cmd.commit) begin
			ok           <= (act_q == ACT_FREE) ? free_hit : alloc_hit;
			block_offset <= ((act_q == ACT_ALLOC) && alloc_hit) ? new_off : 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TABLE_SLOTS; k++) begin
				off_q[k] <= '0;
				len_q[k] <= '0;
			end
		end else if (cmd.commit) begin
			for (int k = 0; k < TABLE_SLOTS; k++) begin
				off_q[k] <= nxt_off[k];
				len_q[k] <= nxt_len[k];
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/sorted_table_heap_allocator.sv =====
// ----------------------------------------------------------------------------
// sorted_table_heap_allocator
// Byte allocator over a heap, backed by a sorted (offset, size) table; tail first, else first fitting gap.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel in_valid/in_stall carries one word: action (0 allocate,
//   1 free), req_size and free_offset. Response channel out_valid/out_stall
//   carries ok and block_offset (0 unless an allocate succeeds).
//   A request is scanned, then committed: the scan compares every table slot in
//   parallel (fit and match flags are registered), the commit picks the tail
//   slot if it fits, else the first fitting gap, and shifts the table. The
//   result is registered at commit, and a new request is accepted in that
//   commit step while out_stall stays low.
//   The result sits in an output register; the next request is accepted and
//   scanned while it waits. If out_stall holds, the commit step waits until
//   the register is free, and in_stall stays high meanwhile.
//   Reset clears the table to all-empty slots and drops any pending result;
//   requests are taken from the first cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_table_heap_allocator import shta_pkg::*; #(
	parameter int HEAP_BYTES  = HEAP_BYTES_DEF,
	parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic       action,
	input  wire logic [7:0] req_size,
	input  wire logic [7:0] free_offset,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            ok,
	output logic [7:0]      block_offset
);

	dp_cmd_t cmd;

	shta_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	shta_dp #(
		.HEAP_BYTES  (HEAP_BYTES),
		.TABLE_SLOTS (TABLE_SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.action       (action),
		.req_size     (req_size),
		.free_offset  (free_offset),
		.ok           (ok),
		.block_offset (block_offset)
	);

endmodule

`default_nettype wire

// ===== verif/sorted_table_heap_allocator_test.sv =====
// ----------------------------------------------------------------------------
// sorted_table_heap_allocator_test
// Drives allocate and free words into the allocator, mirrors its offset table
// in a local tail-first model and checks every ok and block_offset in order.
// Covers the request limits, tail, head and inner-gap placement, a full table,
// unmatched frees, a long output hold and random traffic with idle bursts.
// ----------------------------------------------------------------------------
module sorted_table_heap_allocator_test import shta_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HEAP        = HEAP_BYTES_DEF;
	localparam int SLOTS       = TABLE_SLOTS_DEF;
	localparam int STALL_LIMIT = 1000;

	typedef struct {
		logic       ok;
		logic [7:0] offset;
	} alloc_result_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic       action;
	logic [7:0] req_size;
	logic [7:0] free_offset;
	logic       out_valid;
	logic       out_stall;
	logic       ok;
	logic [7:0] block_offset;

	logic [7:0]    heap_base [SLOTS];
	logic [7:0]    heap_len [SLOTS];
	alloc_result_t pending_results [$];
	alloc_result_t head_result;

	int  err_cnt;
	int  idle_cycles;
	int  hold_request;
	bit  tx_gaps_on;
	bit  rx_gaps_on;

	sorted_table_heap_allocator #(
		.HEAP_BYTES (HEAP),
		.TABLE_SLOTS(SLOTS)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.req_size    (req_size),
		.free_offset (free_offset),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.ok          (ok),
		.block_offset(block_offset)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int live_entries();
		int n;
		n = 0;
		for (int k = 0; k < SLOTS; k++)
			if (heap_len[k] != 0)
				n++;
		return n;
	endfunction

	function automatic void make_room(input int at);
		for (int k = SLOTS - 1; k > at; k--) begin
			heap_base[k] = heap_base[k - 1];
			heap_len[k]  = heap_len[k - 1];
		end
	endfunction

	function automatic logic place_block(input int want, output logic [7:0] at);
		int tail_end;
		at = '0;
		if (heap_len[SLOTS - 1] != 0 || want == 0 || want > HEAP)
			return 1'b0;
		if (heap_len[0] == 0) begin
			heap_base[0] = '0;
			heap_len[0]  = want[7:0];
			return 1'b1;
		end
		for (int k = 1; k < SLOTS; k++) begin
			if (heap_len[k] == 0) begin
				tail_end = int'(heap_base[k - 1]) + int'(heap_len[k - 1]);
				if (want <= HEAP - tail_end) begin
					heap_base[k] = tail_end[7:0];
					heap_len[k]  = want[7:0];
					at = tail_end[7:0];
					return 1'b1;
				end
				break;
			end
		end
		if (want <= int'(heap_base[0])) begin
			make_room(0);
			heap_base[0] = '0;
			heap_len[0]  = want[7:0];
			return 1'b1;
		end
		for (int k = 1; k < SLOTS; k++) begin
			if (heap_len[k] == 0)
				return 1'b0;
			tail_end = int'(heap_base[k - 1]) + int'(heap_len[k - 1]);
			if (want <= int'(heap_base[k]) - tail_end) begin
				make_room(k);
				heap_base[k] = tail_end[7:0];
				heap_len[k]  = want[7:0];
				at = tail_end[7:0];
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic logic release_block(input logic [7:0] at);
		for (int k = 0; k < SLOTS; k++) begin
			if (heap_len[k] != 0 && heap_base[k] == at) begin
				for (int j = k; j < SLOTS - 1; j++) begin
					heap_base[j] = heap_base[j + 1];
					heap_len[j]  = heap_len[j + 1];
				end
				heap_base[SLOTS - 1] = '0;
				heap_len[SLOTS - 1]  = '0;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic void predict_word(input logic act, input logic [7:0] size,
			input logic [7:0] off);
		alloc_result_t res;
		res.offset = '0;
		if (act == ACT_ALLOC)
			res.ok = place_block(int'(size), res.offset);
		else
			res.ok = release_block(off);
		pending_results.push_back(res);
	endfunction

	task automatic send_word(input logic act, input logic [7:0] size, input logic [7:0] off);
		if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		in_valid    = 1'b1;
		action      = act;
		req_size    = size;
		free_offset = off;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_word(act, size, off);
		@(negedge clk);
	endtask

	task automatic alloc_word(input int size);
		send_word(ACT_ALLOC, size[7:0], 8'($urandom_range(0, 254)));
	endtask

	task automatic free_word(input int off);
		send_word(ACT_FREE, 8'($urandom_range(0, 255)), off[7:0]);
	endtask

	task automatic clear_heap();
		while (live_entries() != 0)
			free_word(heap_base[0]);
	endtask

	task automatic random_word();
		int pick;
		int n;
		pick = $urandom_range(0, 99);
		n = live_entries();
		if (pick < 50) begin
			pick = $urandom_range(0, 99);
			if (pick < 80)
				alloc_word($urandom_range(1, 24));
			else if (pick < 90)
				alloc_word($urandom_range(25, HEAP));
			else if (pick < 95)
				alloc_word(0);
			else
				alloc_word($urandom_range(HEAP + 1, 255));
		end else if (pick < 85 && n != 0) begin
			free_word(heap_base[$urandom_range(0, n - 1)]);
		end else begin
			free_word($urandom_range(0, 254));
		end
	endtask

	task automatic test_request_limits();
		free_word(0);
		alloc_word(0);
		alloc_word(HEAP + 1);
		alloc_word(255);
		alloc_word(HEAP);
		alloc_word(1);
		free_word(254);
		free_word(0);
	endtask

	task automatic test_gap_placement();
		repeat (4) alloc_word(HEAP / 4);
		free_word(0);
		free_word(HEAP / 2);
		alloc_word(HEAP / 8);
		alloc_word(HEAP / 4);
		alloc_word(HEAP / 4 - 1);
		free_word(HEAP / 8 + 1);
		clear_heap();
	endtask

	task automatic test_full_table();
		repeat (SLOTS) alloc_word(4);
		alloc_word(1);
		clear_heap();
	endtask

	task automatic test_output_hold();
		hold_request = 150;
		repeat (30) random_word();
	endtask

	task automatic test_random_traffic();
		for (int i = 0; i < 1600; i++) begin
			if (i % 100 == 0) begin
				tx_gaps_on = ($urandom_range(0, 3) != 0);
				rx_gaps_on = ($urandom_range(0, 3) != 0);
			end
			random_word();
		end
	endtask

	task automatic test_steady_stream();
		tx_gaps_on = 1'b0;
		rx_gaps_on = 1'b0;
		repeat (120) random_word();
	endtask

	task automatic flag_mismatch(input string what, input int want, input int got);
		if (err_cnt < 10)
			$display("mismatch on %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
		err_cnt++;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				flag_mismatch("unexpected word, pending count", 0, 1);
			end else begin
				head_result = pending_results.pop_front();
				if (ok !== head_result.ok)
					flag_mismatch("ok", head_result.ok, ok);
				if (block_offset !== head_result.offset)
					flag_mismatch("block_offset", head_result.offset, block_offset);
			end
		end
	end

	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				out_stall = 1'b1;
				repeat (hold_request - 1) @(negedge clk);
				hold_request = 0;
			end else if (rx_gaps_on && $urandom_range(0, 5) == 0) begin
				out_stall = 1'b1;
				repeat ($urandom_range(0, 5)) @(negedge clk);
			end else begin
				out_stall = 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("[sorted_table_heap_allocator] ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		action       = ACT_ALLOC;
		req_size     = '0;
		free_offset  = '0;
		err_cnt      = 0;
		idle_cycles  = 0;
		hold_request = 0;
		tx_gaps_on   = 1'b1;
		rx_gaps_on   = 1'b1;
		for (int k = 0; k < SLOTS; k++) begin
			heap_base[k] = '0;
			heap_len[k]  = '0;
		end
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_request_limits();
		test_gap_placement();
		test_full_table();
		test_output_hold();
		test_random_traffic();
		test_steady_stream();

		in_valid = 1'b0;
		wait (pending_results.size() == 0);
		repeat (10) @(posedge clk);
		if (err_cnt == 0)
			$display("[sorted_table_heap_allocator] OK");
		else
			$display("[sorted_table_heap_allocator] ERROR");
		$finish;
	end

endmodule
